// ===== src/idw_pkg.sv =====
// ----------------------------------------------------------------------------
// IDW package
// Shared types, constants and codes of the inverse distance grid interpolator.
// ----------------------------------------------------------------------------
package idw_pkg;

  localparam int MAX_POINTS_DEF      = 64;
  localparam int NODE_INDEX_BITS_DEF = 12;

  localparam int POS_W  = 20;
  localparam int VAL_W  = 24;
  localparam int ROOT_W = 32;
  localparam int SREM_W = 34;
  localparam int D2_W   = 64;
  localparam int WGT_W  = 25;

  localparam int SQ_STAGES = 32;
  localparam int RD_STAGES = 25;
  localparam int PW_STAGES = 7;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_LOAD  = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  localparam logic REG_SPACING = 1'b0;
  localparam logic REG_POWER   = 1'b1;

  localparam logic [19:0] SPACING_RST = 20'd256;
  localparam logic [2:0]  POWER_RST   = 3'd2;

  localparam logic [WGT_W-1:0] W_ONE = WGT_W'(1 << 24);

  typedef struct packed {
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] b;
    logic signed [VAL_W-1:0] c;
  } trip_t;

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] z;
    trip_t            v;
  } pt_t;

endpackage

// ===== src/inverse_distance_grid_interpolator.sv =====
// ----------------------------------------------------------------------------
// Inverse distance grid interpolator
// Shepard interpolation of three properties over a ring of stored points.
// ----------------------------------------------------------------------------
// Clear and load beats complete at their start beat and leave busy low.
// A query with no points loaded puts its result beat out in the cycle after the start beat.
// A coincident query gives its result after one ring turn drained through the weight
// pipeline; any other query after two ring turns, each drained through the weight pipeline,
// and three bit-serial divisions. One query at a time; results cannot be stalled. Reset
// clears the point count and the configuration registers.
module inverse_distance_grid_interpolator #(
  parameter int MAX_POINTS      = idw_pkg::MAX_POINTS_DEF,
  parameter int NODE_INDEX_BITS = idw_pkg::NODE_INDEX_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [19:0] point_x_i,
  input  logic [19:0] point_z_i,
  input  logic signed [23:0] value_a_i,
  input  logic signed [23:0] value_b_i,
  input  logic signed [23:0] value_c_i,
  input  logic [11:0] node_row_i,
  input  logic [11:0] node_col_i,
  output logic        result_valid_o,
  output logic signed [23:0] interp_a_o,
  output logic signed [23:0] interp_b_o,
  output logic signed [23:0] interp_c_o,
  output logic signed [24:0] doubled_a_o,
  output logic        empty_flag_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import idw_pkg::*;

  localparam int CB      = $clog2(MAX_POINTS + 1);
  localparam int IB      = (NODE_INDEX_BITS < 12) ? NODE_INDEX_BITS : 12;
  localparam int NXW     = IB + POS_W;
  localparam int SQ_POS  = 3;
  localparam int RD_POS  = SQ_POS + SQ_STAGES;
  localparam int PW_POS  = RD_POS + RD_STAGES;
  localparam int PR_POS  = PW_POS + PW_STAGES;
  localparam int DRAIN_A = PR_POS + 4;
  localparam int DRAIN_B = PR_POS + 4;
  localparam int CW      = $clog2(MAX_POINTS + DRAIN_B + 2);
  localparam int ACC_W   = 50 + CB;
  localparam int DEN_W   = WGT_W + CB;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]        st_q;
  logic [CW-1:0]     cnt_q;
  logic [CB-1:0]     count_q;
  logic              pass_b_q;
  logic              coin_q;
  trip_t             coin_v_q;
  logic [19:0]       spacing_q;
  logic [2:0]        power_q;
  logic [NXW-1:0]    nx_q;
  logic [NXW-1:0]    nz_q;
  logic [ROOT_W-1:0] dmin_q;
  logic [1:0]        div_sel_q;
  logic              div_start_q;

  logic accept;
  logic do_load;
  logic rotate;
  logic feed;
  logic cfg_wr;

  assign accept  = start && !busy;
  assign do_load = accept && (mode_i == MODE_LOAD) && (count_q < CB'(MAX_POINTS));
  assign rotate  = (st_q == S_SCAN);
  assign feed    = rotate &&
                   (({1'b0, cnt_q} + (CW+1)'(count_q)) >= (CW+1)'(MAX_POINTS));
  assign busy    = (st_q != S_IDLE);
  assign result_valid_o = (st_q == S_OUT);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign prdata  = (paddr[2] == REG_POWER) ? {29'd0, power_q} : {12'd0, spacing_q};

  // Point ring.
  pt_t ring_d  [MAX_POINTS];
  pt_t ring_q  [MAX_POINTS];
  pt_t new_pt;
  pt_t top_pt;

  assign new_pt = '{x: point_x_i, z: point_z_i,
                    v: '{a: value_a_i, b: value_b_i, c: value_c_i}};
  assign top_pt = ring_q[MAX_POINTS-1];

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_ring
    if (i == 0) begin : g_head
      assign ring_d[i] = do_load ? new_pt : top_pt;
    end else begin : g_body
      assign ring_d[i] = ring_q[i-1];
    end
    idw_pt_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (do_load || rotate),
      .pt_i    (ring_d[i]),
      .pt_o    (ring_q[i])
    );
  end

  // Distance front end.
  logic [NXW:0]   dfx;
  logic [NXW:0]   dfz;
  logic [32:0]    mgx;
  logic [32:0]    mgz;
  logic [30:0]    dx_q;
  logic [30:0]    dz_q;
  logic [61:0]    sqx_q;
  logic [61:0]    sqz_q;
  logic [62:0]    d2_q;

  always_comb begin
    dfx = {1'b0, nx_q} - (NXW+1)'(top_pt.x);
    dfz = {1'b0, nz_q} - (NXW+1)'(top_pt.z);
    mgx = dfx[NXW] ? 33'(-dfx) : 33'(dfx);
    mgz = dfz[NXW] ? 33'(-dfz) : 33'(dfz);
    if (dfx[NXW]) begin
      mgx = 33'(NXW'(-dfx));
    end
    if (dfz[NXW]) begin
      mgz = 33'(NXW'(-dfz));
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q  <= (mgx > 33'h7FFF_FFFF) ? 31'h7FFF_FFFF : mgx[30:0];
    dz_q  <= (mgz > 33'h7FFF_FFFF) ? 31'h7FFF_FFFF : mgz[30:0];
    sqx_q <= dx_q * dx_q;
    sqz_q <= dz_q * dz_q;
    d2_q  <= 63'(sqx_q) + 63'(sqz_q);
  end

  // Valid and value delay lines.
  logic  vld_q  [PR_POS+1];
  trip_t vals_q [PR_POS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j <= PR_POS; j++) begin
        vld_q[j] <= 1'b0;
      end
    end else begin
      vld_q[0] <= feed;
      for (int j = 1; j <= PR_POS; j++) begin
        vld_q[j] <= vld_q[j-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    vals_q[0] <= top_pt.v;
    for (int j = 1; j < PR_POS; j++) begin
      vals_q[j] <= vals_q[j-1];
    end
  end

  // Square root chain.
  logic [SREM_W-1:0] sq_rem  [SQ_STAGES+1];
  logic [ROOT_W-1:0] sq_root [SQ_STAGES+1];
  logic [D2_W-1:0]   sq_src  [SQ_STAGES+1];

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_src[0]  = {1'b0, d2_q};

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
    idw_sqrt_cell u_sq (
      .clk_i  (clk_i),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .src_i  (sq_src[k]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_root[k+1]),
      .src_o  (sq_src[k+1])
    );
  end

  // Ratio divider chain.
  logic [ROOT_W-1:0] rd_rem [RD_STAGES+1];
  logic [WGT_W-1:0]  rd_quo [RD_STAGES+1];
  logic [ROOT_W-1:0] rd_den [RD_STAGES+1];

  assign rd_rem[0] = {1'b0, dmin_q[ROOT_W-1:1]};
  assign rd_quo[0] = '0;
  assign rd_den[0] = sq_root[SQ_STAGES];

  for (genvar k = 0; k < RD_STAGES; k++) begin : g_rdiv
    idw_rdiv_cell u_rd (
      .clk_i  (clk_i),
      .rem_i  (rd_rem[k]),
      .quo_i  (rd_quo[k]),
      .nbit_i ((k == 0) ? dmin_q[0] : 1'b0),
      .den_i  (rd_den[k]),
      .rem_o  (rd_rem[k+1]),
      .quo_o  (rd_quo[k+1]),
      .den_o  (rd_den[k+1])
    );
  end

  // Power stages.
  logic [WGT_W-1:0] pw_w [PW_STAGES+1];
  logic [WGT_W-1:0] pw_r [PW_STAGES+1];
  logic [2*WGT_W-1:0] pw_p [PW_STAGES];

  assign pw_w[0] = W_ONE;
  assign pw_r[0] = rd_quo[RD_STAGES];

  for (genvar k = 0; k < PW_STAGES; k++) begin : g_pow
    assign pw_p[k] = pw_w[k] * pw_r[k];
    always_ff @(posedge clk_i) begin
      pw_w[k+1] <= (3'(k) < power_q) ? pw_p[k][48:24] : pw_w[k];
      pw_r[k+1] <= pw_r[k];
    end
  end

  // Weighted products and sums.
  logic signed [49:0]       pa_q;
  logic signed [49:0]       pb_q;
  logic signed [49:0]       pc_q;
  logic [WGT_W-1:0]         pwt_q;
  logic signed [ACC_W-1:0]  sa_q;
  logic signed [ACC_W-1:0]  sb_q;
  logic signed [ACC_W-1:0]  sc_q;
  logic [DEN_W-1:0]         den_q;
  trip_t                    pv;

  assign pv = vals_q[PR_POS-1];

  always_ff @(posedge clk_i) begin
    pa_q  <= $signed({1'b0, pw_w[PW_STAGES]}) * pv.a;
    pb_q  <= $signed({1'b0, pw_w[PW_STAGES]}) * pv.b;
    pc_q  <= $signed({1'b0, pw_w[PW_STAGES]}) * pv.c;
    pwt_q <= pw_w[PW_STAGES];
  end

  // Final divisions.
  logic signed [ACC_W-1:0] sel_sum;
  logic [ACC_W-1:0]        sel_mag;
  logic [ACC_W-1:0]        div_num;
  logic                    div_done;
  logic [ACC_W-1:0]        div_quo;
  logic [VAL_W-1:0]        res_mag;
  logic [VAL_W-1:0]        res;

  always_comb begin
    case (div_sel_q)
      2'd0:    sel_sum = sa_q;
      2'd1:    sel_sum = sb_q;
      default: sel_sum = sc_q;
    endcase
    sel_mag = sel_sum[ACC_W-1] ? ACC_W'(-sel_sum) : ACC_W'(sel_sum);
    div_num = sel_mag + ACC_W'(den_q >> 1);
    res_mag = div_quo[VAL_W-1:0];
    res     = sel_sum[ACC_W-1] ? VAL_W'(-res_mag) : res_mag;
  end

  idw_div #(
    .NUM_W (ACC_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .num_i   (div_num),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q <= SPACING_RST;
      power_q   <= POWER_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_SPACING) begin
        spacing_q <= pwdata[19:0];
      end else begin
        power_q <= pwdata[2:0];
      end
    end
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      cnt_q       <= '0;
      count_q     <= '0;
      pass_b_q    <= 1'b0;
      coin_q      <= 1'b0;
      div_sel_q   <= '0;
      div_start_q <= 1'b0;
    end else begin
      case (st_q)
        S_IDLE: begin
          if (accept) begin
            if (mode_i == MODE_CLEAR) begin
              count_q <= '0;
            end else if (do_load) begin
              count_q <= count_q + 1'b1;
            end else if (mode_i == MODE_QUERY) begin
              if (count_q == '0) begin
                st_q <= S_OUT;
              end else begin
                st_q     <= S_SCAN;
                cnt_q    <= '0;
                pass_b_q <= 1'b0;
                coin_q   <= 1'b0;
              end
            end
          end
        end
        S_SCAN: begin
          if (cnt_q == CW'(MAX_POINTS - 1)) begin
            st_q  <= S_DRAIN;
            cnt_q <= '0;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_DRAIN: begin
          if (pass_b_q && cnt_q == CW'(DRAIN_B)) begin
            st_q      <= S_DIV;
            div_sel_q <= '0;
          end else if (!pass_b_q && cnt_q == CW'(DRAIN_A)) begin
            if (coin_q) begin
              st_q <= S_OUT;
            end else begin
              st_q     <= S_SCAN;
              cnt_q    <= '0;
              pass_b_q <= 1'b1;
            end
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (div_sel_q == 2'd2) begin
              st_q <= S_OUT;
            end else begin
              div_sel_q <= div_sel_q + 1'b1;
            end
          end
        end
        S_OUT: begin
          st_q <= S_IDLE;
        end
        default: begin
          st_q <= S_IDLE;
        end
      endcase
      div_start_q <= (st_q == S_DRAIN && pass_b_q && cnt_q == CW'(DRAIN_B)) ||
                     (st_q == S_DIV && div_done && div_sel_q != 2'd2);
      if (!pass_b_q && rotate == 1'b0 && st_q == S_DRAIN && vld_q[2] && d2_q == '0) begin
        coin_q <= 1'b1;
      end
      if (!pass_b_q && st_q == S_SCAN && vld_q[2] && d2_q == '0) begin
        coin_q <= 1'b1;
      end
    end
  end

  // Datapath registers of the sequencer.
  always_ff @(posedge clk_i) begin
    if (accept && mode_i == MODE_QUERY) begin
      nz_q   <= node_row_i[IB-1:0] * spacing_q;
      nx_q   <= node_col_i[IB-1:0] * spacing_q;
      dmin_q <= '1;
      if (count_q == '0) begin
        interp_a_o   <= '0;
        interp_b_o   <= '0;
        interp_c_o   <= '0;
        doubled_a_o  <= '0;
        empty_flag_o <= 1'b1;
      end
    end
    if (!pass_b_q && !coin_q && vld_q[2] && d2_q == '0) begin
      coin_v_q <= vals_q[2];
    end
    if (!pass_b_q && vld_q[RD_POS-1] && sq_root[SQ_STAGES] < dmin_q) begin
      dmin_q <= sq_root[SQ_STAGES];
    end
    if (st_q == S_DRAIN && !pass_b_q && cnt_q == CW'(DRAIN_A)) begin
      sa_q  <= '0;
      sb_q  <= '0;
      sc_q  <= '0;
      den_q <= '0;
      if (coin_q) begin
        interp_a_o   <= coin_v_q.a;
        interp_b_o   <= coin_v_q.b;
        interp_c_o   <= coin_v_q.c;
        doubled_a_o  <= {coin_v_q.a, 1'b0};
        empty_flag_o <= 1'b0;
      end
    end else if (pass_b_q && vld_q[PR_POS]) begin
      sa_q  <= sa_q + ACC_W'(pa_q);
      sb_q  <= sb_q + ACC_W'(pb_q);
      sc_q  <= sc_q + ACC_W'(pc_q);
      den_q <= den_q + DEN_W'(pwt_q);
    end
    if (st_q == S_DIV && div_done) begin
      empty_flag_o <= 1'b0;
      case (div_sel_q)
        2'd0: begin
          interp_a_o  <= res;
          doubled_a_o <= {res, 1'b0};
        end
        2'd1:    interp_b_o <= res;
        default: interp_c_o <= res;
      endcase
    end
  end

endmodule

// ===== src/idw_pt_cell.sv =====
// ----------------------------------------------------------------------------
// IDW point cell
// One control point of the storage ring; shifts to its neighbor when enabled.
// ----------------------------------------------------------------------------
module idw_pt_cell (
  input  logic          clk_i,
  input  logic          shift_i,
  input  idw_pkg::pt_t  pt_i,
  output idw_pkg::pt_t  pt_o
);
  import idw_pkg::*;

  pt_t pt_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      pt_q <= pt_i;
    end
  end

  assign pt_o = pt_q;

endmodule

// ===== src/idw_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// IDW square root cell
// One stage of the pipelined integer square root; resolves one root bit.
// ----------------------------------------------------------------------------
module idw_sqrt_cell (
  input  logic                       clk_i,
  input  logic [idw_pkg::SREM_W-1:0] rem_i,
  input  logic [idw_pkg::ROOT_W-1:0] root_i,
  input  logic [idw_pkg::D2_W-1:0]   src_i,
  output logic [idw_pkg::SREM_W-1:0] rem_o,
  output logic [idw_pkg::ROOT_W-1:0] root_o,
  output logic [idw_pkg::D2_W-1:0]   src_o
);
  import idw_pkg::*;

  logic [SREM_W+1:0] rem_n;
  logic [SREM_W+1:0] trial;
  logic              ge;

  always_comb begin
    rem_n = {rem_i, src_i[D2_W-1:D2_W-2]};
    trial = (SREM_W+2)'({root_i, 2'b01});
    ge    = rem_n >= trial;
  end

  always_ff @(posedge clk_i) begin
    rem_o  <= ge ? SREM_W'(rem_n - trial) : SREM_W'(rem_n);
    root_o <= {root_i[ROOT_W-2:0], ge};
    src_o  <= {src_i[D2_W-3:0], 2'b00};
  end

endmodule

// ===== src/idw_rdiv_cell.sv =====
// ----------------------------------------------------------------------------
// IDW ratio divider cell
// One stage of the pipelined divider that forms dmin / d in Q.24.
// ----------------------------------------------------------------------------
module idw_rdiv_cell (
  input  logic                       clk_i,
  input  logic [idw_pkg::ROOT_W-1:0] rem_i,
  input  logic [idw_pkg::WGT_W-1:0]  quo_i,
  input  logic                       nbit_i,
  input  logic [idw_pkg::ROOT_W-1:0] den_i,
  output logic [idw_pkg::ROOT_W-1:0] rem_o,
  output logic [idw_pkg::WGT_W-1:0]  quo_o,
  output logic [idw_pkg::ROOT_W-1:0] den_o
);
  import idw_pkg::*;

  logic [ROOT_W:0] rem_n;
  logic            ge;

  always_comb begin
    rem_n = {rem_i, nbit_i};
    ge    = rem_n >= {1'b0, den_i};
  end

  always_ff @(posedge clk_i) begin
    rem_o <= ge ? ROOT_W'(rem_n - {1'b0, den_i}) : ROOT_W'(rem_n);
    quo_o <= {quo_i[WGT_W-2:0], ge};
    den_o <= den_i;
  end

endmodule

// ===== src/idw_div.sv =====
// ----------------------------------------------------------------------------
// IDW final divider
// Iterative restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module idw_div #(
  parameter int NUM_W = 57,
  parameter int DEN_W = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);
  localparam int CW = $clog2(NUM_W + 1);

  logic [CW-1:0]    cnt_q;
  logic             run_q;
  logic             done_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [NUM_W-1:0] acc_q;
  logic [DEN_W:0]   rem_n;
  logic             ge;

  always_comb begin
    rem_n = {rem_q, acc_q[NUM_W-1]};
    ge    = rem_n >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      if (start_i) begin
        cnt_q  <= '0;
        run_q  <= 1'b1;
        done_q <= 1'b0;
      end else if (run_q && cnt_q == CW'(NUM_W - 1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end else if (run_q) begin
        cnt_q  <= cnt_q + 1'b1;
        done_q <= 1'b0;
      end else begin
        done_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= den_i;
      acc_q <= num_i;
    end else if (run_q) begin
      rem_q <= ge ? DEN_W'(rem_n - {1'b0, den_q}) : DEN_W'(rem_n);
      acc_q <= {acc_q[NUM_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = acc_q;

endmodule

// ===== tb/sv/inverse_distance_grid_interpolator_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Inverse distance grid interpolator testbench
// Drives clear, load, query and skip beats through the start/busy port, writes the
// spacing and power registers over APB between phases, and checks every query
// result against a bit-exact Shepard interpolation predictor or a fixed expectation.
// ----------------------------------------------------------------------------
module inverse_distance_grid_interpolator_test;
  import idw_pkg::*;

  localparam logic [1:0] MODE_SKIP    = 2'd3;
  localparam logic [2:0] ADDR_SPACING = 3'd0;
  localparam logic [2:0] ADDR_POWER   = 3'd4;
  localparam int         STALL_LIMIT  = 5000;
  localparam int         POINT_CAP    = MAX_POINTS_DEF;

  typedef struct {
    logic signed [23:0] a;
    logic signed [23:0] b;
    logic signed [23:0] c;
    logic signed [24:0] dbl;
    logic               empty;
  } node_result_t;

  typedef struct {
    logic [1:0]         mode;
    logic [19:0]        px;
    logic [19:0]        pz;
    logic signed [23:0] va;
    logic signed [23:0] vb;
    logic signed [23:0] vc;
    logic [11:0]        row;
    logic [11:0]        col;
    bit                 typed;
    node_result_t       res;
  } beat_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         mode_i = MODE_SKIP;
  logic [19:0]        point_x_i = '0;
  logic [19:0]        point_z_i = '0;
  logic signed [23:0] value_a_i = '0;
  logic signed [23:0] value_b_i = '0;
  logic signed [23:0] value_c_i = '0;
  logic [11:0]        node_row_i = '0;
  logic [11:0]        node_col_i = '0;
  logic               result_valid_o;
  logic signed [23:0] interp_a_o;
  logic signed [23:0] interp_b_o;
  logic signed [23:0] interp_c_o;
  logic signed [24:0] doubled_a_o;
  logic               empty_flag_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  logic [19:0]        spacing;
  logic [2:0]         power;
  logic [19:0]        pts_x[POINT_CAP];
  logic [19:0]        pts_z[POINT_CAP];
  logic signed [23:0] pts_a[POINT_CAP];
  logic signed [23:0] pts_b[POINT_CAP];
  logic signed [23:0] pts_c[POINT_CAP];
  int                 pts_count;

  node_result_t       pending_results[$];
  beat_t              directed_rows[$];
  int                 mismatches = 0;
  int                 quiet_cycles = 0;
  int                 idle_pct = 0;

  inverse_distance_grid_interpolator i_dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned span_sq(int i, longint nx, longint nz);
    longint dx;
    longint dz;
    dx = nx - longint'(pts_x[i]);
    dz = nz - longint'(pts_z[i]);
    if (dx < 0) dx = -dx;
    if (dz < 0) dz = -dz;
    if (dx > 64'sd2147483647) dx = 64'sd2147483647;
    if (dz > 64'sd2147483647) dz = 64'sd2147483647;
    return longint'(dx * dx) + longint'(dz * dz);
  endfunction

  function automatic longint weighted_mean(longint num, longint unsigned den);
    longint unsigned mag;
    longint unsigned q;
    mag = (num < 0) ? longint'(-num) : longint'(num);
    q = (mag + den / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic node_result_t interpolate_node(logic [11:0] row, logic [11:0] col);
    node_result_t    res;
    longint          nx;
    longint          nz;
    longint unsigned d2;
    longint unsigned d;
    longint unsigned dmin;
    longint unsigned r;
    longint unsigned w;
    longint unsigned den;
    longint          sa;
    longint          sb;
    longint          sc;
    longint          ma;
    res = '{a: '0, b: '0, c: '0, dbl: '0, empty: 1'b0};
    if (pts_count == 0) begin
      res.empty = 1'b1;
      return res;
    end
    nz = longint'(row) * longint'(spacing);
    nx = longint'(col) * longint'(spacing);
    dmin = '1;
    for (int i = 0; i < pts_count; i++) begin
      d2 = span_sq(i, nx, nz);
      if (d2 == 0) begin
        res.a = pts_a[i];
        res.b = pts_b[i];
        res.c = pts_c[i];
        res.dbl = {pts_a[i], 1'b0};
        return res;
      end
      d = int_sqrt(d2);
      if (d < dmin) dmin = d;
    end
    den = 0;
    sa = 0;
    sb = 0;
    sc = 0;
    for (int i = 0; i < pts_count; i++) begin
      d = int_sqrt(span_sq(i, nx, nz));
      r = (dmin << 24) / d;
      w = 64'd1 << 24;
      for (int k = 0; k < power; k++) w = (w * r) >> 24;
      den += w;
      sa += longint'(w) * longint'(pts_a[i]);
      sb += longint'(w) * longint'(pts_b[i]);
      sc += longint'(w) * longint'(pts_c[i]);
    end
    ma = weighted_mean(sa, den);
    res.a = ma[23:0];
    res.b = 24'(weighted_mean(sb, den));
    res.c = 24'(weighted_mean(sc, den));
    res.dbl = 25'(ma * 2);
    return res;
  endfunction

  task automatic issue_beat(beat_t bt);
    int gaps;
    gaps = 0;
    while (gaps < 20 && $urandom_range(99) < idle_pct) gaps++;
    if (gaps > 0) begin
      start <= 1'b0;
      repeat (gaps) @(posedge clk_i);
    end
    start      <= 1'b1;
    mode_i     <= bt.mode;
    point_x_i  <= bt.px;
    point_z_i  <= bt.pz;
    value_a_i  <= bt.va;
    value_b_i  <= bt.vb;
    value_c_i  <= bt.vc;
    node_row_i <= bt.row;
    node_col_i <= bt.col;
    do @(posedge clk_i); while (busy);
    case (bt.mode)
      MODE_CLEAR: begin
        pts_count = 0;
      end
      MODE_LOAD: begin
        if (pts_count < POINT_CAP) begin
          pts_x[pts_count] = bt.px;
          pts_z[pts_count] = bt.pz;
          pts_a[pts_count] = bt.va;
          pts_b[pts_count] = bt.vb;
          pts_c[pts_count] = bt.vc;
          pts_count++;
        end
      end
      MODE_QUERY: begin
        pending_results.push_back(bt.typed ? bt.res : interpolate_node(bt.row, bt.col));
      end
      default: ;
    endcase
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0 || busy);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_SPACING) spacing = data[19:0];
    else power = data[2:0];
  endtask

  task automatic add_row(logic [1:0] mode, logic [19:0] px, logic [19:0] pz,
                         logic signed [23:0] va, logic signed [23:0] vb,
                         logic signed [23:0] vc, logic [11:0] row, logic [11:0] col,
                         bit typed, node_result_t res);
    directed_rows.push_back('{mode, px, pz, va, vb, vc, row, col, typed, res});
  endtask

  function automatic beat_t random_beat(logic [1:0] mode);
    beat_t bt;
    bt.mode = mode;
    bt.px = 20'($urandom);
    bt.pz = 20'($urandom);
    bt.va = 24'($urandom);
    bt.vb = 24'($urandom);
    bt.vc = 24'($urandom);
    bt.row = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(15));
    bt.col = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(15));
    if (mode == MODE_LOAD && $urandom_range(1) == 0) begin
      bt.px = 20'(bt.col * spacing);
      bt.pz = 20'(bt.row * spacing);
    end
    bt.typed = 1'b0;
    return bt;
  endfunction

  always @(posedge clk_i) begin
    node_result_t want;
    if (rst_ni) begin
      if ((start && !busy) || result_valid_o) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no query outstanding");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (interp_a_o !== want.a) begin
          $error("interp_a: expected %0d, got %0d", want.a, interp_a_o);
          mismatches++;
        end
        if (interp_b_o !== want.b) begin
          $error("interp_b: expected %0d, got %0d", want.b, interp_b_o);
          mismatches++;
        end
        if (interp_c_o !== want.c) begin
          $error("interp_c: expected %0d, got %0d", want.c, interp_c_o);
          mismatches++;
        end
        if (doubled_a_o !== want.dbl) begin
          $error("doubled_a: expected %0d, got %0d", want.dbl, doubled_a_o);
          mismatches++;
        end
        if (empty_flag_o !== want.empty) begin
          $error("empty_flag: expected %0d, got %0d", want.empty, empty_flag_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    node_result_t none;
    node_result_t empty_res;
    node_result_t first_hit;
    beat_t        bt;
    int           spacings[6];
    int           powers[6];
    int           pcts[6];
    int           nload;
    int           nquery;
    int           sent;
    spacing = SPACING_RST;
    power = POWER_RST;
    pts_count = 0;
    none = '{a: '0, b: '0, c: '0, dbl: '0, empty: 1'b0};
    empty_res = none;
    empty_res.empty = 1'b1;
    first_hit = '{a: 24'sd8388607, b: -24'sd8388608, c: '0, dbl: 25'sd16777214,
                  empty: 1'b0};
    spacings = '{256, 1, 1048575, 0, 16, 256};
    powers   = '{2, 1, 4, 0, 7, 3};
    pcts     = '{0, 45, 0, 21, 45, 0};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(MODE_QUERY, 0, 0, 0, 0, 0, 0, 0, 1, empty_res);
    add_row(MODE_LOAD, 0, 0, 24'sd8388607, -24'sd8388608, 0, 0, 0, 0, none);
    add_row(MODE_QUERY, 0, 0, 0, 0, 0, 0, 0, 1, first_hit);
    add_row(MODE_LOAD, 20'hFFFFF, 20'hFFFFF, -24'sd8388608, 24'sd8388607, -24'sd1,
            0, 0, 0, none);
    add_row(MODE_QUERY, 0, 0, 0, 0, 0, 12'hFFF, 12'hFFF, 0, none);
    add_row(MODE_QUERY, 0, 0, 0, 0, 0, 0, 1, 0, none);
    add_row(MODE_QUERY, 0, 0, 0, 0, 0, 12'hFFF, 0, 0, none);
    add_row(MODE_SKIP, 20'hFFFFF, 20'hFFFFF, -1, -1, -1, 12'hFFF, 12'hFFF, 0, none);
    add_row(MODE_LOAD, 0, 0, 24'sd5, 24'sd6, 24'sd7, 0, 0, 0, none);
    add_row(MODE_QUERY, 0, 0, 0, 0, 0, 0, 0, 1, first_hit);
    add_row(MODE_LOAD, 20'h00100, 20'h00200, 24'sd1000, -24'sd1000, 24'sd3, 0, 0, 0, none);
    add_row(MODE_QUERY, 0, 0, 0, 0, 0, 1, 1, 0, none);
    add_row(MODE_QUERY, 0, 0, 0, 0, 0, 2, 1, 0, none);
    add_row(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, none);
    add_row(MODE_QUERY, 0, 0, 0, 0, 0, 3, 3, 1, empty_res);
    foreach (directed_rows[i]) issue_beat(directed_rows[i]);
    wait_all_results();

    sent = 0;
    for (int ph = 0; ph < 6; ph++) begin
      wait_all_results();
      apb_write(ADDR_SPACING, 32'(spacings[ph] == 16 ? $urandom_range(1, 1048575)
                                                     : spacings[ph]));
      apb_write(ADDR_POWER, 32'(powers[ph]));
      idle_pct = pcts[ph];
      while (sent < (ph + 1) * 72) begin
        if ($urandom_range(9) == 0) begin
          issue_beat(random_beat(MODE_SKIP));
          continue;
        end
        if ($urandom_range(3) != 0) begin
          issue_beat(random_beat(MODE_CLEAR));
          sent++;
        end
        nload = ($urandom_range(11) == 0) ? $urandom_range(60, 68) : $urandom_range(1, 8);
        repeat (nload) begin
          issue_beat(random_beat(MODE_LOAD));
          sent++;
        end
        nquery = $urandom_range(1, 5);
        repeat (nquery) begin
          bt = random_beat(MODE_QUERY);
          issue_beat(bt);
          sent++;
        end
        if ($urandom_range(7) == 0) begin
          issue_beat(random_beat(MODE_QUERY));
          sent++;
          wait_all_results();
        end
      end
    end

    wait_all_results();
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
